// ===== sv/scm_pkg.sv =====
// Shared types, constants and helpers for the saturating channel mixer.
package scm_pkg;

   // Field widths fixed by the item format
   localparam int SampleW = 32;
   localparam int DivW    = 31;
   localparam int ChanW   = 2;
   localparam int CsrIdxW = 3;

   // Defaults for top-level parameters
   localparam int ChannelsDefault   = 4;
   localparam int QueueDepthDefault = 2;

   // Configuration register indexes
   typedef logic [CsrIdxW-1:0] csr_index_type;
   localparam csr_index_type CsrVolDiv0 = 3'd0;
   localparam csr_index_type CsrVolDiv1 = 3'd1;
   localparam csr_index_type CsrVolDiv2 = 3'd2;
   localparam csr_index_type CsrVolDiv3 = 3'd3;
   localparam csr_index_type CsrOutMono = 3'd4;

   localparam logic signed [SampleW-1:0] SampleMax = 32'sh7FFF_FFFF;
   localparam logic signed [SampleW-1:0] SampleMin = 32'sh8000_0000;

   // Input item
   typedef struct packed {
      logic [ChanW-1:0]          chan;
      logic signed [SampleW-1:0] gen_left;
      logic signed [SampleW-1:0] gen_right;
      logic                      gen_mono;
      logic                      frame_end;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [SampleW-1:0] mix_left;
      logic signed [SampleW-1:0] mix_right;
   } rsp_type;

   // Classified item handed from front to back through the queue
   typedef struct packed {
      logic signed [SampleW-1:0] gen_left;
      logic signed [SampleW-1:0] gen_right;
      logic [DivW-1:0]           divisor;
      logic                      active;
      logic                      gen_mono;
      logic                      out_mono;
      logic                      frame_end;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_ADD_L,
      BK_ADD_R,
      BK_EMIT
   } back_state_type;

   // 32-bit signed add, clamped to the representable range
   function automatic logic signed [SampleW-1:0] sat_add(
      input logic signed [SampleW-1:0] a,
      input logic signed [SampleW-1:0] b
   );
      logic signed [SampleW:0] sum;
      sum = {a[SampleW-1], a} + {b[SampleW-1], b};
      if (sum[SampleW] != sum[SampleW-1]) begin
         return sum[SampleW] ? SampleMin : SampleMax;
      end
      return sum[SampleW-1:0];
   endfunction

endpackage

// ===== sv/scm_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake.
interface scm_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/saturating_channel_mixer.sv =====
// Top level of the saturating channel mixer: front, item queue and back.
// An accepted item passes through the queue, then the two side-by-side 32-step restoring
// dividers, the quotient latch, the left and right adds and, on a frame end item, the emit
// state; a mono source skips the right add, and a channel out of range skips divide and adds.
// The back takes the next item from the queue only when done with the current one, so the
// 32-step divider loop sets the item rate; the queue holds further items meanwhile.
// Reset clears the accumulators, the queue and the output valid, sets every
// volume divisor to one and selects stereo output.
module saturating_channel_mixer
   import scm_pkg::*;
#(
   parameter int CHANNELS    = ChannelsDefault,
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  csr_index_type   csr_index,
   input  logic [DivW-1:0] csr_wdata,
   scm_stream_if.sink      req_bus,
   scm_stream_if.source    rsp_bus
);

   logic    push;
   logic    not_full;
   logic    pop;
   logic    not_empty;
   cmd_type push_data;
   cmd_type pop_data;

   scm_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .q_ready   (not_full),
      .q_push    (push),
      .q_data    (push_data)
   );

   scm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   scm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== sv/scm_front.sv =====
// Front end: holds the configuration registers, accepts and classifies items.
module scm_front
   import scm_pkg::*;
#(
   parameter int CHANNELS = ChannelsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [DivW-1:0]    csr_wdata,
   scm_stream_if.sink         req_bus,
   input  logic               q_ready,
   output logic               q_push,
   output cmd_type            q_data
);

   localparam int ChanLimitW = ChanW + 1;
   localparam logic [ChanLimitW-1:0] ChanLimit = ChanLimitW'(CHANNELS);

   logic [DivW-1:0] vol_div_ff [4];
   logic [DivW-1:0] vol_div_in [4];
   logic            out_mono_ff;
   logic            out_mono_in;
   logic [DivW-1:0] div_sel;

   // Register writes
   always_comb begin
      vol_div_in  = vol_div_ff;
      out_mono_in = out_mono_ff;
      if (csr_we) begin
         case (csr_index)
            CsrVolDiv0: vol_div_in[0] = csr_wdata;
            CsrVolDiv1: vol_div_in[1] = csr_wdata;
            CsrVolDiv2: vol_div_in[2] = csr_wdata;
            CsrVolDiv3: vol_div_in[3] = csr_wdata;
            CsrOutMono: out_mono_in   = csr_wdata[0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            vol_div_ff[i] <= DivW'(1);
         end
         out_mono_ff <= 1'b0;
      end else begin
         vol_div_ff  <= vol_div_in;
         out_mono_ff <= out_mono_in;
      end
   end

   // Classify the item: divisor lookup (zero acts as one), channel range check
   assign div_sel = vol_div_ff[req_bus.data.chan];

   always_comb begin
      q_data.gen_left  = req_bus.data.gen_left;
      q_data.gen_right = req_bus.data.gen_right;
      q_data.divisor   = (div_sel == '0) ? DivW'(1) : div_sel;
      q_data.active    = {1'b0, req_bus.data.chan} < ChanLimit;
      q_data.gen_mono  = req_bus.data.gen_mono;
      q_data.out_mono  = out_mono_ff;
      q_data.frame_end = req_bus.data.frame_end;
   end

   assign req_bus.ready = q_ready;
   assign q_push        = req_bus.valid & q_ready;

endmodule

// ===== sv/scm_queue.sv =====
// Short FIFO of classified items between the front and the back.
module scm_queue
   import scm_pkg::*;
#(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign not_full  = count_ff != CntW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/scm_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module scm_divider
   import scm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SampleW-1:0] dividend,
   input  logic [DivW-1:0]           divisor,
   output logic                      done,
   output logic signed [SampleW-1:0] quotient
);

   localparam int CntW = $clog2(SampleW);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [SampleW-1:0] quo_ff, quo_in;
   logic [DivW-1:0]    rem_ff, rem_in;
   logic [DivW-1:0]    div_ff, div_in;
   logic [SampleW-1:0] trial;
   logic [SampleW-1:0] diff;
   logic               fits;

   // One trial subtraction per cycle
   assign trial = {rem_ff, quo_ff[SampleW-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[SampleW-1];
         quo_in  = dividend[SampleW-1] ? -dividend : dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SampleW-2:0], fits};
         rem_in = fits ? diff[DivW-1:0] : trial[DivW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(SampleW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // Sign restore; magnitude of at most 2^31 wraps correctly to the minimum
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   // Never restarted mid-division
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// ===== sv/scm_back.sv =====
// Back end: divides, accumulates with saturation and emits the frame sums.
module scm_back
   import scm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_data,
   output logic    q_pop,
   scm_stream_if.source rsp_bus
);

   back_state_type            state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic signed [SampleW-1:0] ql_ff, ql_in;
   logic signed [SampleW-1:0] qr_ff, qr_in;
   logic signed [SampleW-1:0] acc_left_ff, acc_left_in;
   logic signed [SampleW-1:0] acc_right_ff, acc_right_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;
   logic                      div_start;
   logic                      done_l, done_r;
   logic signed [SampleW-1:0] quot_l, quot_r;
   logic                      can_emit;

   // Left and right lanes divide side by side
   scm_divider u_div_l (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_data.gen_left),
      .divisor  (q_data.divisor),
      .done     (done_l),
      .quotient (quot_l)
   );

   scm_divider u_div_r (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_data.gen_right),
      .divisor  (q_data.divisor),
      .done     (done_r),
      .quotient (quot_r)
   );

   assign can_emit = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      acc_left_in  = acc_left_ff;
      acc_right_in = acc_right_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               if (q_data.active) begin
                  div_start = 1'b1;
                  state_in  = BK_DIV;
               end else if (q_data.frame_end) begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_DIV: begin
            if (done_l) begin
               ql_in    = quot_l;
               qr_in    = quot_r;
               state_in = BK_ADD_L;
            end
         end
         BK_ADD_L: begin
            acc_left_in = sat_add(acc_left_ff, ql_ff);
            // mono source feeds both sides in stereo output
            if (cmd_ff.gen_mono && !cmd_ff.out_mono) begin
               acc_right_in = sat_add(acc_right_ff, ql_ff);
            end
            if (!cmd_ff.gen_mono) begin
               state_in = BK_ADD_R;
            end else begin
               state_in = cmd_ff.frame_end ? BK_EMIT : BK_IDLE;
            end
         end
         BK_ADD_R: begin
            // stereo source folded onto left in mono output
            if (cmd_ff.out_mono) begin
               acc_left_in = sat_add(acc_left_ff, qr_ff);
            end else begin
               acc_right_in = sat_add(acc_right_ff, qr_ff);
            end
            state_in = cmd_ff.frame_end ? BK_EMIT : BK_IDLE;
         end
         BK_EMIT: begin
            if (can_emit) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.mix_left  = acc_left_ff;
               rsp_data_in.mix_right = cmd_ff.out_mono ? '0 : acc_right_ff;
               acc_left_in           = '0;
               acc_right_in          = '0;
               state_in              = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_left_ff  <= acc_left_in;
         acc_right_ff <= acc_right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ql_ff       <= ql_in;
      qr_ff       <= qr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // Both lanes start together, so they must finish together
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_l == done_r)
      else $error("divider lanes out of step");

   // Emitting a frame leaves both accumulators cleared
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) && can_emit |=> (acc_left_ff == '0) && (acc_right_ff == '0))
      else $error("accumulators not cleared after frame");

   // Mono output carries a zero right sample
   a_mono_right_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) && can_emit && cmd_ff.out_mono |=> rsp_data_ff.mix_right == '0)
      else $error("right sample not zero in mono output");

endmodule
